/* src/lru_page_replacement_core_assert.svh */
// assertion macros for the lru page replacement core
// expects clk and rst_n in the scope where a macro is used
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LRUPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru core check failed");

// next-cycle implication
`define LRUPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru core check failed");

`else

`define LRUPR_ASSERT_NOW(lbl, ante, cons)
`define LRUPR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/lrupr_pkg.sv */
// shared types and constants for the lru page replacement core
// no dependencies
package lrupr_pkg;

  localparam int FAULT_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0]   RESET_FRAMES = CFG_W'(16);
  localparam logic [FAULT_W-1:0] FAULT_MAX    = {FAULT_W{1'b1}};

  // handed from one cell to the next
  typedef struct packed {
    logic valid;     // slot holds a resident page
    logic no_match;  // no hit in this slot or any more recent one
  } lrupr_link_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic upd;    // a reference is taken this cycle
    logic evict;  // miss with the set full
  } lrupr_ctrl_t;

endpackage

/* src/lrupr_cell.sv */
// one recency slot of the lru chain: tag, valid bit, compare and shift
// depends on lrupr_pkg
module lrupr_cell #(
  parameter int PAGE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrupr_pkg::lrupr_ctrl_t ctrl,
  input  logic [PAGE_BITS-1:0]   page,
  input  logic [PAGE_BITS-1:0]   prev_tag,
  input  lrupr_pkg::lrupr_link_t prev_link,
  input  logic                   next_valid,
  input  logic [PAGE_BITS-1:0]   ev_in,
  output logic [PAGE_BITS-1:0]   tag_q,
  output lrupr_pkg::lrupr_link_t link_o,
  output logic [PAGE_BITS-1:0]   ev_out
);
  import lrupr_pkg::*;

  logic [PAGE_BITS-1:0] tag_r;
  logic                 valid_r;
  logic                 valid_nxt;
  logic                 match;
  logic                 shift;

  assign match = valid_r && (tag_r == page);

  // take the neighbor's entry when the move-to-front reaches this slot
  assign shift = ctrl.upd && prev_link.no_match && prev_link.valid &&
                 (!ctrl.evict || valid_r);

  assign valid_nxt = shift ? prev_link.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tag_r <= prev_tag;
    end
  end

  assign tag_q           = tag_r;
  assign link_o.valid    = valid_r;
  assign link_o.no_match = prev_link.no_match && !match;

  // the last resident slot supplies the victim
  assign ev_out = ev_in | ((ctrl.evict && valid_r && !next_valid) ? tag_r : '0);

endmodule

/* src/lru_page_replacement_core.sv */
// lru page replacement core: chain of MAX_FRAMES cells kept in recency order
// a result is registered and shows in the cycle after its reference transfer
// throughput: one reference per cycle, set by the combinational compare and shift
// across the cell chain; stalls only while a finished result is held by out_stall
// reset (rst_n low, synchronous): all slots empty, fault count 0, frames 16
// depends on lrupr_pkg, lrupr_cell and lru_page_replacement_core_assert.svh
`include "lru_page_replacement_core_assert.svh"

module lru_page_replacement_core #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // reference channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [PAGE_BITS-1:0]         in_page_number,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_fault,
  output logic                         out_evicted_valid,
  output logic [PAGE_BITS-1:0]         out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0] out_fault_count,
  // frame count register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_active_frames
);
  import lrupr_pkg::*;

  // wide enough for the frame count and the built maximum
  localparam int LIM_W = ($clog2(MAX_FRAMES + 1) > CFG_W) ? $clog2(MAX_FRAMES + 1) : CFG_W;

  // frame count register, always writable
  logic [CFG_W-1:0] frames_r;
  logic [CFG_W-1:0] frames_nxt;

  assign cfg_ready  = 1'b1;
  assign frames_nxt = (cfg_valid && cfg_ready) ? cfg_active_frames : frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= RESET_FRAMES;
    end else begin
      frames_r <= frames_nxt;
    end
  end

  // clamp to 1..MAX_FRAMES, kept as an index of the last usable slot
  logic [LIM_W-1:0] frames_w;
  logic [LIM_W-1:0] lim_m1;

  assign frames_w = LIM_W'(frames_r);

  always_comb begin
    if (frames_w == '0) begin
      lim_m1 = '0;
    end else if (frames_w > LIM_W'(MAX_FRAMES)) begin
      lim_m1 = LIM_W'(MAX_FRAMES - 1);
    end else begin
      lim_m1 = frames_w - LIM_W'(1);
    end
  end

  // input handshake: the output register parts the two sides
  logic out_valid_r;
  logic in_xfer;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // cell chain, slot 0 is the most recently used
  lrupr_ctrl_t                ctrl;
  lrupr_link_t                links [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0]       tags  [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0]       evs   [0:MAX_FRAMES];
  logic [MAX_FRAMES:0]        nvalid;
  logic [MAX_FRAMES-1:0]      valid_vec;
  logic                       hit;
  logic                       full;

  // the chain head feeds the new page in front of slot 0
  assign links[0].valid    = 1'b1;
  assign links[0].no_match = 1'b1;
  assign tags[0]           = in_page_number;
  assign evs[0]            = '0;
  assign nvalid[MAX_FRAMES] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_FRAMES; g++) begin : g_cell
      lrupr_cell #(
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .page       (in_page_number),
        .prev_tag   (tags[g]),
        .prev_link  (links[g]),
        .next_valid (nvalid[g+1]),
        .ev_in      (evs[g]),
        .tag_q      (tags[g+1]),
        .link_o     (links[g+1]),
        .ev_out     (evs[g+1])
      );
      assign valid_vec[g] = links[g+1].valid;
      assign nvalid[g]    = links[g+1].valid;
    end
  endgenerate

  // the no-match ripple through the chain gives the hit
  assign hit = !links[MAX_FRAMES].no_match;

  // valid bits form a run from slot 0, so the set is full when the slot
  // at the frame limit is occupied
  always_comb begin
    full = 1'b0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (lim_m1 == LIM_W'(k)) begin
        full = valid_vec[k];
      end
    end
  end

  assign ctrl.upd   = in_xfer;
  assign ctrl.evict = !hit && full;

  // saturating fault counter
  logic [FAULT_W-1:0] fault_cnt_r;
  logic [FAULT_W-1:0] fault_cnt_nxt;

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (in_xfer && !hit && (fault_cnt_r != FAULT_MAX)) begin
      fault_cnt_nxt = fault_cnt_r + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_cnt_r <= '0;
    end else begin
      fault_cnt_r <= fault_cnt_nxt;
    end
  end

  // result register
  logic                 out_valid_nxt;
  logic                 fault_r;
  logic                 ev_valid_r;
  logic [PAGE_BITS-1:0] ev_page_r;
  logic [FAULT_W-1:0]   cnt_out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fault_r    <= !hit;
      ev_valid_r <= ctrl.evict;
      ev_page_r  <= evs[MAX_FRAMES];
      cnt_out_r  <= fault_cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = fault_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_fault_count   = cnt_out_r;

  // checks
  // resident slots always form an unbroken run from the most recent slot
  `LRUPR_ASSERT_NOW(a_valid_run, 1'b1, ((valid_vec & (valid_vec >> 1)) == (valid_vec >> 1)))
  // a hit never changes how many pages are resident
  `LRUPR_ASSERT_NEXT(a_hit_keeps_count, in_xfer && hit, $countones(valid_vec) == $past($countones(valid_vec)))
  // an eviction is only reported together with a fault
  `LRUPR_ASSERT_NOW(a_evict_is_fault, out_valid_r && ev_valid_r, fault_r)
  // the fault count never goes down
  `LRUPR_ASSERT_NEXT(a_count_monotonic, 1'b1, fault_cnt_r >= $past(fault_cnt_r))

endmodule

/* sim/lru_page_replacement_core_test.sv */
// self-checking bench for lru_page_replacement_core: page references in, hit/fault results out
// depends on lrupr_pkg and the core rtl; predicts each result from its own recency list
`timescale 1ns / 1ps

module lru_page_replacement_core_test;

  localparam int MAX_FRAMES    = 16;
  localparam int PAGE_BITS     = 20;
  localparam int FAULT_W       = lrupr_pkg::FAULT_W;
  localparam int CFG_W         = lrupr_pkg::CFG_W;
  localparam int REF_TARGET    = 2000;  // references to send in total
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;     // result is registered in the cycle after transfer
  localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer before giving up
  localparam int REPORT_LIMIT  = 10;

  // one result transfer, field for field
  typedef struct packed {
    logic                 fault;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PAGE_BITS-1:0] in_page_number;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_fault;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [FAULT_W-1:0]   out_fault_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_active_frames;

  lru_page_replacement_core #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fault        (out_fault),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_count  (out_fault_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_frames(cfg_active_frames)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // recency list kept alongside the core: slot 0 is most recent, valid slots
  // always form a run starting at slot 0
  // ---------------------------------------------------------------------------
  logic [PAGE_BITS-1:0] page_slot [MAX_FRAMES];
  logic                 slot_used [MAX_FRAMES];
  logic [FAULT_W-1:0]   faults_seen;
  logic [CFG_W-1:0]     frames_set;

  outcome_t outcome_q[$];     // results still owed by the core, oldest first
  int       refs_sent      = 0;
  int       mismatch_count = 0;
  bit       idle_on        = 1'b0;  // random gaps and stalls allowed
  int       hold_asked     = 0;     // bumped by a test to request a long hold-off

  function automatic void clear_frames();
    for (int k = 0; k < MAX_FRAMES; k++) begin
      page_slot[k] = '0;
      slot_used[k] = 1'b0;
    end
    faults_seen = '0;
    frames_set  = lrupr_pkg::RESET_FRAMES;
  endfunction

  // look the page up, reorder the list and work out the owed result
  function automatic outcome_t replace_page(logic [PAGE_BITS-1:0] page);
    outcome_t res;
    int       used;
    int       limit;
    int       hit_at;
    int       last;
    used   = 0;
    res    = '0;
    while (used < MAX_FRAMES && slot_used[used]) used++;
    // zero acts as one frame, anything above the built maximum as the maximum
    limit  = (frames_set < 1) ? 1 : (frames_set > MAX_FRAMES) ? MAX_FRAMES : int'(frames_set);
    hit_at = used;
    for (int k = 0; k < used; k++) begin
      if (hit_at == used && page_slot[k] == page) hit_at = k;
    end
    if (hit_at < used) begin
      last = hit_at;
    end else begin
      res.fault = 1'b1;
      // lowered frame count: only the oldest page goes, occupancy stays put
      if (used >= limit) begin
        res.evicted_valid = 1'b1;
        res.evicted_page  = page_slot[used-1];
        last              = used - 1;
      end else begin
        last = used;
      end
      if (faults_seen != lrupr_pkg::FAULT_MAX) faults_seen++;
    end
    for (int k = last; k > 0; k--) begin
      page_slot[k] = page_slot[k-1];
      slot_used[k] = slot_used[k-1];
    end
    page_slot[0]    = page;
    slot_used[0]    = 1'b1;
    res.fault_count = faults_seen;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: compare every transfer against the oldest owed result
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        flag_mismatch("unexpected result transfer", 64'd0, 64'd1);
      end else begin
        want = outcome_q.pop_front();
        if (out_fault !== want.fault)
          flag_mismatch("fault", want.fault, out_fault);
        if (out_evicted_valid !== want.evicted_valid)
          flag_mismatch("evicted_valid", want.evicted_valid, out_evicted_valid);
        if (out_evicted_page !== want.evicted_page)
          flag_mismatch("evicted_page", want.evicted_page, out_evicted_page);
        if (out_fault_count !== want.fault_count)
          flag_mismatch("fault_count", want.fault_count, out_fault_count);
      end
    end
  end

  // receiver stall: short random bursts, rare long ones, plus a requested hold-off
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: any transfer on any channel restarts the count
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // reference side
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one reference and hold it until the core takes it; valid stays up
  // into the next reference unless a gap is chosen
  task automatic offer_page(input logic [PAGE_BITS-1:0] page);
    int gap;
    in_valid       <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (in_stall);
    outcome_q = {outcome_q, replace_page(page)};
    refs_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and let every owed result drain out
  task automatic settle_block();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frame count is only written with the core idle
  task automatic set_frames(input logic [CFG_W-1:0] frames);
    settle_block();
    cfg_valid         <= 1'b1;
    cfg_active_frames <= frames;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    frames_set = frames;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset set is empty even though stored tags are not cleared; extremes of the page field
  task automatic test_reset_state();
    offer_page('0);
    offer_page('0);
    offer_page('1);
    offer_page(20'h55555);
    offer_page(20'hAAAAA);
    offer_page('0);
    settle_block();
  endtask

  // zero acts as one frame, values past the maximum act as the maximum, and a
  // lowered count leaves resident pages in place
  task automatic test_frame_limits();
    set_frames('0);
    offer_page(20'h00001);
    offer_page(20'hAAAAA);
    offer_page(20'h00002);
    set_frames('1);
    offer_page(20'h00003);
    offer_page(20'h00004);
    set_frames(CFG_W'(1));
    offer_page(20'h00005);
    offer_page(20'h00004);
    set_frames(CFG_W'(MAX_FRAMES + 1));
    offer_page(20'h00006);
    set_frames(lrupr_pkg::RESET_FRAMES);
    offer_page(20'h00007);
    settle_block();
  endtask

  // receiver holds off long enough for the core to back up and stall its input,
  // then the sender waits for the backlog to empty
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_asked++;
    for (int k = 0; k < 30; k++) offer_page(PAGE_BITS'($urandom_range(0, 7)));
    settle_block();
  endtask

  // phases of random frame counts with working sets sized around them; the
  // fault counter can't be driven to saturation in a run of this length
  task automatic test_random_traffic();
    logic [CFG_W-1:0]     picks [] = '{0, 1, 2, 3, 4, 7, 8, 15, 16, 17, 31};
    logic [PAGE_BITS-1:0] pool [];
    logic [PAGE_BITS-1:0] page;
    int                   phase_len;
    int                   r;
    while (refs_sent < REF_TARGET) begin
      if ($urandom_range(0, 3) == 0)
        set_frames(CFG_W'($urandom_range(0, 31)));
      else
        set_frames(picks[$urandom_range(0, picks.size() - 1)]);
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(40, 200);
      pool      = new[$urandom_range(1, 24)];
      foreach (pool[k]) pool[k] = PAGE_BITS'($urandom());
      repeat (phase_len) begin
        r = $urandom_range(0, 9);
        if (r < 7)
          page = pool[$urandom_range(0, pool.size() - 1)];
        else if (r == 7)
          page = PAGE_BITS'($urandom());
        else if (r == 8)
          page = ~pool[$urandom_range(0, pool.size() - 1)];
        else  // near miss: one bit off a resident candidate
          page = pool[$urandom_range(0, pool.size() - 1)] ^ (PAGE_BITS'(1) << $urandom_range(0, PAGE_BITS - 1));
        offer_page(page);
      end
    end
    settle_block();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_page_number    = '0;
    cfg_valid         = 1'b0;
    cfg_active_frames = lrupr_pkg::RESET_FRAMES;
    clear_frames();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_frame_limits();
    test_backpressure();
    test_random_traffic();

    // anything still owed at this point never arrived
    if (outcome_q.size() != 0) flag_mismatch("results never delivered", 0, outcome_q.size());
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
